/* design/prp_pkg.sv */
`default_nettype none
package prp_pkg;
    localparam int MAX_FRAMES = 128;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    localparam logic [31:0] NRU_PERIOD = 32'd48;
    localparam logic [31:0] WS_WINDOW  = 32'd49;
    localparam logic [2:0]  NO_CLASS   = 3'd4;

    localparam logic [2:0] POL_FIFO  = 3'd0;
    localparam logic [2:0] POL_CLOCK = 3'd1;
    localparam logic [2:0] POL_NRU   = 3'd2;
    localparam logic [2:0] POL_AGING = 3'd3;
    localparam logic [2:0] POL_WSET  = 3'd4;

    localparam logic [1:0] OP_ACCESS = 2'd0;
    localparam logic [1:0] OP_MAP    = 2'd1;
    localparam logic [1:0] OP_VICTIM = 2'd2;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_FRAMES = 2'd1;

    // Outcome of evaluating one frame during a victim scan.
    typedef struct packed {
        logic        clr_ref;
        logic        wr_en;
        logic [31:0] wr_data;
        logic        take;
        logic        stop;
        logic [2:0]  new_cls;
        logic [31:0] new_val;
    } t_eval;
endpackage
`default_nettype wire

/* design/page_replacement_policy.sv */
`default_nettype none
// Channel      Handshake                    Payload
// command      start / busy                 i_op, i_frame, i_is_write, i_now
// result       o_result_valid (strobe)      o_victim_frame, o_victim_dirty
// config       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Access and map commands complete at the accepting edge; busy stays low.
// A victim request holds busy while the hand is reduced modulo the frame
// count (one subtraction per cycle), then through a memory read and an
// evaluate-and-write-back step per frame visited, at most n frames (n + 1
// for clock, none for fifo), and a final state that publishes the result.
// The strobe rises as busy falls and cannot be stalled; config writes wait
// while busy. Reset is synchronous; age and stamp memories read as zero
// through per-entry valid bits, so no clearing pass runs.
module page_replacement_policy (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [6:0]  i_frame,
    input  wire logic        i_is_write,
    input  wire logic [31:0] i_now,
    output logic             o_result_valid,
    output logic [6:0]       o_victim_frame,
    output logic             o_victim_dirty,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    localparam int FW = prp_pkg::FRAME_W;
    localparam int CW = prp_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_EV   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]  r_state;
    logic [2:0]  r_policy;
    logic [7:0]  r_active;
    logic [CW-1:0] r_n;
    logic [FW-1:0] r_hand, r_i, r_best;
    logic [CW-1:0] r_cnt;
    logic [31:0] r_lcr, r_now;
    logic        r_clear;
    logic [2:0]  r_best_cls;
    logic [31:0] r_best_val;
    logic [prp_pkg::MAX_FRAMES-1:0] r_ref, r_mod, r_age_vld, r_lut_vld;
    logic [31:0] r_age_mem [prp_pkg::MAX_FRAMES];
    logic [31:0] r_lut_mem [prp_pkg::MAX_FRAMES];
    logic [31:0] r_age_q, r_lut_q;
    logic        r_age_qv, r_lut_qv;
    logic        r_out_vld;
    logic [FW-1:0] r_out_frame;
    logic        r_out_dirty;

    logic [2:0]  pol;
    logic [CW-1:0] frames_eff;
    logic        accept, frame_ok;
    logic [CW-1:0] idx_inc;
    logic [FW-1:0] idx_next;
    prp_pkg::t_eval ev;

    // Fold unknown policy codes onto fifo and clamp the frame count.
    always_comb begin
        pol = (r_policy > prp_pkg::POL_WSET) ? prp_pkg::POL_FIFO : r_policy;
        if (r_active == 8'd0) begin
            frames_eff = CW'(1);
        end else if ({1'b0, r_active} > 9'(prp_pkg::MAX_FRAMES)) begin
            frames_eff = CW'(prp_pkg::MAX_FRAMES);
        end else begin
            frames_eff = CW'(r_active);
        end
        accept   = start && !busy;
        frame_ok = {1'b0, i_frame} < frames_eff;
        idx_inc  = {1'b0, r_i} + CW'(1);
        idx_next = (idx_inc == r_n) ? '0 : idx_inc[FW-1:0];
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = (r_state == ST_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_victim_frame = r_out_frame;
    assign o_victim_dirty = r_out_dirty;

    prp_eval u_eval (
        .i_policy   (pol),
        .i_ref      (r_ref[r_i]),
        .i_mod      (r_mod[r_i]),
        .i_age      (r_age_qv ? r_age_q : 32'd0),
        .i_lut      (r_lut_qv ? r_lut_q : 32'd0),
        .i_now      (r_now),
        .i_clear    (r_clear),
        .i_first    (r_cnt == '0),
        .i_best_cls (r_best_cls),
        .i_best_val (r_best_val),
        .o_ev       (ev)
    );

    // Memories: registered read of the scan entry; one write port each.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD) begin
            r_age_q <= r_age_mem[r_i];
            r_lut_q <= r_lut_mem[r_i];
        end
        if (r_state == ST_EV && ev.wr_en && pol == prp_pkg::POL_AGING) begin
            r_age_mem[r_i] <= ev.wr_data;
        end
        if (r_state == ST_EV && ev.wr_en && pol == prp_pkg::POL_WSET) begin
            r_lut_mem[r_i] <= ev.wr_data;
        end else if (accept && i_op == prp_pkg::OP_MAP && frame_ok
                     && pol == prp_pkg::POL_WSET) begin
            r_lut_mem[i_frame] <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_policy   <= prp_pkg::POL_FIFO;
            r_active   <= 8'(prp_pkg::MAX_FRAMES);
            r_ref      <= '0;
            r_mod      <= '0;
            r_age_vld  <= '0;
            r_lut_vld  <= '0;
            r_hand     <= '0;
            r_lcr      <= '1;
            r_out_vld  <= 1'b0;
            r_n        <= CW'(1);
            r_i        <= '0;
            r_best     <= '0;
            r_cnt      <= '0;
            r_clear    <= 1'b0;
            r_best_cls <= prp_pkg::NO_CLASS;
            r_best_val <= '1;
            r_now      <= '0;
            r_age_qv   <= 1'b0;
            r_lut_qv   <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    prp_pkg::CFG_POLICY: r_policy <= i_cfg_data[2:0];
                    prp_pkg::CFG_FRAMES: r_active <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_op)
                            prp_pkg::OP_ACCESS: begin
                                if (frame_ok) begin
                                    r_ref[i_frame] <= 1'b1;
                                    if (i_is_write) r_mod[i_frame] <= 1'b1;
                                end
                            end
                            prp_pkg::OP_MAP: begin
                                if (frame_ok) begin
                                    r_ref[i_frame] <= 1'b1;
                                    r_mod[i_frame] <= i_is_write;
                                    if (pol == prp_pkg::POL_AGING) begin
                                        r_age_vld[i_frame] <= 1'b0;
                                    end
                                    if (pol == prp_pkg::POL_WSET) begin
                                        r_lut_vld[i_frame] <= 1'b1;
                                    end
                                end
                            end
                            prp_pkg::OP_VICTIM: begin
                                r_n        <= frames_eff;
                                r_i        <= r_hand;
                                r_now      <= i_now;
                                r_clear    <= (i_now - r_lcr) >= prp_pkg::NRU_PERIOD;
                                r_cnt      <= '0;
                                r_best_cls <= prp_pkg::NO_CLASS;
                                r_best_val <= '1;
                                r_state    <= ST_MOD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MOD: begin
                    // Reduce the hand one subtraction per cycle.
                    if ({1'b0, r_i} >= r_n) begin
                        r_i <= r_i - r_n[FW-1:0];
                    end else begin
                        r_best  <= r_i;
                        r_state <= (pol == prp_pkg::POL_FIFO) ? ST_DONE : ST_RD;
                    end
                end
                ST_RD: begin
                    r_age_qv <= r_age_vld[r_i];
                    r_lut_qv <= r_lut_vld[r_i];
                    r_state  <= ST_EV;
                end
                ST_EV: begin
                    if (ev.clr_ref) r_ref[r_i] <= 1'b0;
                    if (ev.wr_en && pol == prp_pkg::POL_AGING) r_age_vld[r_i] <= 1'b1;
                    if (ev.wr_en && pol == prp_pkg::POL_WSET) r_lut_vld[r_i] <= 1'b1;
                    if (ev.take) r_best <= r_i;
                    r_best_cls <= ev.new_cls;
                    r_best_val <= ev.new_val;
                    r_cnt      <= r_cnt + CW'(1);
                    r_i        <= idx_next;
                    if (ev.stop || (pol != prp_pkg::POL_CLOCK && r_cnt + CW'(1) == r_n)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_RD;
                    end
                end
                ST_DONE: begin
                    // Publish the victim and advance the hand past it.
                    r_out_vld   <= 1'b1;
                    r_out_frame <= r_best;
                    r_out_dirty <= r_mod[r_best];
                    r_hand      <= ({1'b0, r_best} + CW'(1) == r_n) ? '0 : r_best + FW'(1);
                    if (pol == prp_pkg::POL_NRU && r_clear) r_lcr <= r_now;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |=> !r_out_vld) else $error("result strobe longer than one cycle");
    a_victim_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == prp_pkg::OP_VICTIM) |=> busy)
        else $error("victim request did not start a scan");
    a_victim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ({1'b0, r_best} < r_n))
        else $error("victim outside active frames");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EV) |-> (r_cnt <= r_n))
        else $error("scan visited too many frames");
endmodule
`default_nettype wire

/* design/prp_eval.sv */
`default_nettype none
// Per-frame evaluation unit, shared by every step of a victim scan.
module prp_eval (
    input  wire logic [2:0]  i_policy,
    input  wire logic        i_ref,
    input  wire logic        i_mod,
    input  wire logic [31:0] i_age,
    input  wire logic [31:0] i_lut,
    input  wire logic [31:0] i_now,
    input  wire logic        i_clear,
    input  wire logic        i_first,
    input  wire logic [2:0]  i_best_cls,
    input  wire logic [31:0] i_best_val,
    output prp_pkg::t_eval   o_ev
);
    logic [2:0]  cls;
    logic [31:0] aged;
    logic [31:0] since;

    always_comb begin
        cls   = {1'b0, i_ref, i_mod};
        aged  = {i_ref, i_age[31:1]};
        since = i_now - i_lut;
        o_ev  = '0;
        o_ev.new_cls = i_best_cls;
        o_ev.new_val = i_best_val;
        unique case (i_policy)
            prp_pkg::POL_CLOCK: begin
                o_ev.clr_ref = i_ref;
                o_ev.take    = !i_ref;
                o_ev.stop    = !i_ref;
            end
            prp_pkg::POL_NRU: begin
                o_ev.clr_ref = i_clear;
                o_ev.take    = cls < i_best_cls;
                o_ev.stop    = (cls < i_best_cls) && (cls == 3'd0) && !i_clear;
                if (cls < i_best_cls) begin
                    o_ev.new_cls = cls;
                end
            end
            prp_pkg::POL_AGING: begin
                o_ev.clr_ref = i_ref;
                o_ev.wr_en   = 1'b1;
                o_ev.wr_data = aged;
                o_ev.take    = aged < i_best_val;
                if (aged < i_best_val) begin
                    o_ev.new_val = aged;
                end
            end
            prp_pkg::POL_WSET: begin
                if (i_ref) begin
                    o_ev.clr_ref = 1'b1;
                    o_ev.wr_en   = 1'b1;
                    o_ev.wr_data = i_now;
                    o_ev.take    = i_first || (i_now < i_best_val);
                    if (i_first || (i_now < i_best_val)) begin
                        o_ev.new_val = i_now;
                    end
                end else if (since > prp_pkg::WS_WINDOW) begin
                    o_ev.take = 1'b1;
                    o_ev.stop = 1'b1;
                end else begin
                    o_ev.take = i_first || (i_lut < i_best_val);
                    if (i_first || (i_lut < i_best_val)) begin
                        o_ev.new_val = i_lut;
                    end
                end
            end
            default: begin
                o_ev.take = 1'b1;
                o_ev.stop = 1'b1;
            end
        endcase
    end
endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    // Command row: one victim/access/map transaction plus an optional
    // expected result typed in by hand (has_fixed = 1).
    typedef struct {
        logic [1:0]  op;
        logic [6:0]  frame;
        logic        wr;
        logic [31:0] now;
        logic        has_fixed;
        logic [6:0]  fixed_frame;
        logic        fixed_dirty;
    } t_cmd_row;

    typedef struct {
        logic [6:0] frame;
        logic       dirty;
    } t_victim;

    localparam int CYCLE_LIMIT = 2_000_000;
    // Unused op code, expected to be dropped without a result.
    localparam logic [1:0] OP_RSVD = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = '0;
    logic [6:0]  i_frame = '0;
    logic        i_is_write = 1'b0;
    logic [31:0] i_now = '0;
    logic        o_result_valid;
    logic [6:0]  o_victim_frame;
    logic        o_victim_dirty;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    page_replacement_policy i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state: mirrors the engine's frame table.
    logic [2:0]  pol_q;
    logic [7:0]  frames_q;
    logic        ref_q   [prp_pkg::MAX_FRAMES];
    logic        mod_q   [prp_pkg::MAX_FRAMES];
    logic [31:0] age_q   [prp_pkg::MAX_FRAMES];
    logic [31:0] stamp_q [prp_pkg::MAX_FRAMES];
    logic [31:0] hand_q;
    logic [31:0] class_reset_q;

    t_victim victim_queue[$];
    int errors = 0;
    int n_cmds = 0;
    int n_victims = 0;
    int n_cfg = 0;
    longint cycles = 0;
    int sender_idle = 0;
    logic [31:0] clock_now = 0;

    function automatic int live_frames();
        if (frames_q == 0) return 1;
        if (frames_q > prp_pkg::MAX_FRAMES) return prp_pkg::MAX_FRAMES;
        return frames_q;
    endfunction

    // Run the selected replacement policy over the active frames.
    function automatic t_victim choose_victim(input logic [31:0] now);
        int n, first, i, best, best_cls, cls;
        logic [31:0] min_age;
        logic clr;
        t_victim v;
        n = live_frames();
        first = hand_q % n;
        i = first;
        best = first;
        case (pol_q)
            prp_pkg::POL_CLOCK: begin
                while (ref_q[i]) begin
                    ref_q[i] = 1'b0;
                    i = (i + 1) % n;
                end
                best = i;
            end
            prp_pkg::POL_NRU: begin
                clr = (now - class_reset_q) >= prp_pkg::NRU_PERIOD;
                best_cls = prp_pkg::NO_CLASS;
                do begin
                    cls = 2 * ref_q[i] + mod_q[i];
                    if (cls < best_cls) begin
                        best_cls = cls;
                        best = i;
                        if (cls == 0 && !clr) break;
                    end
                    if (clr) ref_q[i] = 1'b0;
                    i = (i + 1) % n;
                end while (i != first);
                if (clr) class_reset_q = now;
            end
            prp_pkg::POL_AGING: begin
                min_age = '1;
                do begin
                    age_q[i] = age_q[i] >> 1;
                    if (ref_q[i]) begin
                        age_q[i][31] = 1'b1;
                        ref_q[i] = 1'b0;
                    end
                    if (age_q[i] < min_age) begin
                        min_age = age_q[i];
                        best = i;
                    end
                    i = (i + 1) % n;
                end while (i != first);
            end
            prp_pkg::POL_WSET: begin
                do begin
                    if (ref_q[i]) begin
                        stamp_q[i] = now;
                        ref_q[i] = 1'b0;
                    end else if ((now - stamp_q[i]) > prp_pkg::WS_WINDOW) begin
                        best = i;
                        break;
                    end
                    if (stamp_q[i] < stamp_q[best]) best = i;
                    i = (i + 1) % n;
                end while (i != first);
            end
            default: best = first;
        endcase
        hand_q = (best + 1) % n;
        v.frame = best[6:0];
        v.dirty = mod_q[best];
        return v;
    endfunction

    // Apply one accepted command to the predictor; returns 1 on a result.
    function automatic bit predict_cmd(input t_cmd_row c, output t_victim v);
        int n;
        n = live_frames();
        v = '{default: '0};
        case (c.op)
            prp_pkg::OP_ACCESS: if (c.frame < n) begin
                ref_q[c.frame] = 1'b1;
                if (c.wr) mod_q[c.frame] = 1'b1;
            end
            prp_pkg::OP_MAP: if (c.frame < n) begin
                ref_q[c.frame] = 1'b1;
                mod_q[c.frame] = c.wr;
                if (pol_q == prp_pkg::POL_AGING) age_q[c.frame] = '0;
                else if (pol_q == prp_pkg::POL_WSET) stamp_q[c.frame] = c.now;
            end
            prp_pkg::OP_VICTIM: begin
                v = choose_victim(c.now);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Check each result strobe against the oldest expected victim.
    always @(posedge i_clk) begin
        t_victim e;
        cycles <= cycles + 1;
        if (i_rst_n && o_result_valid) begin
            if (victim_queue.size() == 0) begin
                $error("unexpected result frame=%0d dirty=%0d",
                       o_victim_frame, o_victim_dirty);
                errors++;
            end else begin
                e = victim_queue[0];
                victim_queue.delete(0);
                if (o_victim_frame !== e.frame) begin
                    $error("victim_frame expected %0d actual %0d", e.frame, o_victim_frame);
                    errors++;
                end
                if (o_victim_dirty !== e.dirty) begin
                    $error("victim_dirty expected %0d actual %0d", e.dirty, o_victim_dirty);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Write one register; only called while the engine is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == prp_pkg::CFG_POLICY) pol_q = val[2:0];
        else if (idx == prp_pkg::CFG_FRAMES) frames_q = val;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain outstanding victims, then allow the longest scan to finish.
    task automatic settle();
        int guard;
        guard = 0;
        while (victim_queue.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    // Drive one command transaction; hold start until busy drops.
    task automatic send_cmd(input t_cmd_row c);
        t_victim v;
        bit has_res;
        @(negedge i_clk);
        if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= c.op;
        i_frame    <= c.frame;
        i_is_write <= c.wr;
        i_now      <= c.now;
        do @(posedge i_clk); while (busy);
        has_res = predict_cmd(c, v);
        if (has_res) begin
            if (c.has_fixed) begin
                v.frame = c.fixed_frame;
                v.dirty = c.fixed_dirty;
            end
            victim_queue.insert(victim_queue.size(), v);
            n_victims++;
        end
        n_cmds++;
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    function automatic t_cmd_row row(input logic [1:0] op, input logic [6:0] f,
                                     input logic wr, input logic [31:0] now);
        row = '{op: op, frame: f, wr: wr, now: now, has_fixed: 1'b0,
                fixed_frame: '0, fixed_dirty: 1'b0};
    endfunction

    function automatic t_cmd_row fixed(input logic [31:0] now, input logic [6:0] f,
                                       input logic d);
        fixed = '{op: prp_pkg::OP_VICTIM, frame: '0, wr: 1'b0, now: now, has_fixed: 1'b1,
                  fixed_frame: f, fixed_dirty: d};
    endfunction

    // Random command: mostly accesses/maps, some victims, rare noise.
    function automatic t_cmd_row rand_cmd();
        int r, n;
        logic [6:0] f;
        r = $urandom_range(99);
        n = live_frames();
        f = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(n - 1));
        clock_now += $urandom_range(0, 30);
        if (r < 4) return row(OP_RSVD, 7'($urandom), 1'($urandom), $urandom);
        if (r < 40) return row(prp_pkg::OP_ACCESS, f, 1'($urandom), clock_now);
        if (r < 70) return row(prp_pkg::OP_MAP, f, 1'($urandom), clock_now);
        if (r < 73) return row(prp_pkg::OP_VICTIM, f, 1'($urandom), $urandom);
        return row(prp_pkg::OP_VICTIM, f, 1'($urandom), clock_now);
    endfunction

    t_cmd_row directed[$];

    initial begin
        logic [7:0] sizes [6];
        pol_q = prp_pkg::POL_FIFO;
        frames_q = 8'd128;
        for (int k = 0; k < prp_pkg::MAX_FRAMES; k++) begin
            ref_q[k] = 0; mod_q[k] = 0; age_q[k] = 0; stamp_q[k] = 0;
        end
        hand_q = 0;
        class_reset_q = '1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset FIFO walks frames 0, 1 clean; extremes of every field.
        directed.insert(directed.size(), fixed(32'd0, 7'd0, 1'b0));
        directed.insert(directed.size(), fixed(32'hFFFF_FFFF, 7'd1, 1'b0));
        directed.insert(directed.size(), row(prp_pkg::OP_ACCESS, 7'd2, 1'b1, 32'd0));
        directed.insert(directed.size(), fixed(32'd5, 7'd2, 1'b1));
        directed.insert(directed.size(),
                        row(prp_pkg::OP_MAP, 7'd127, 1'b1, 32'hFFFF_FFFF));
        directed.insert(directed.size(),
                        row(prp_pkg::OP_MAP, 7'd3, 1'b0, 32'h5555_5555));
        directed.insert(directed.size(), row(OP_RSVD, 7'd127, 1'b1, 32'hAAAA_AAAA));
        directed.insert(directed.size(),
                        row(prp_pkg::OP_VICTIM, 7'd0, 1'b0, 32'hAAAA_AAAA));
        foreach (directed[k]) send_cmd(directed[k]);
        settle();

        // Each policy with extreme frame counts, incl. zero and above range.
        sizes = '{8'd1, 8'd2, 8'd0, 8'd255, 8'd128, 8'd5};
        for (int p = 0; p < 8; p++) begin
            write_reg(prp_pkg::CFG_POLICY, 8'(p));
            write_reg(prp_pkg::CFG_FRAMES, sizes[p % 6]);
            clock_now = $urandom;
            for (int k = 0; k < 10; k++) send_cmd(rand_cmd());
            send_cmd(row(prp_pkg::OP_VICTIM, 7'd127, 1'b1, clock_now + 100));
            settle();
        end

        // Random phases with shifting idle profile and configuration.
        for (int ph = 0; ph < 21; ph++) begin
            sender_idle = (ph < 7) ? 10 : (ph < 14) ? 61 : 0;
            write_reg(prp_pkg::CFG_POLICY, 8'($urandom_range(0, 7)));
            write_reg(prp_pkg::CFG_FRAMES, ($urandom_range(4) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(1, 12)));
            for (int k = 0; k < 29; k++) send_cmd(rand_cmd());
            settle();
        end

        $display("Ran %0d commands, %0d victims checked, %0d register writes",
                 n_cmds, n_victims, n_cfg);
        $display("over all five policies, frame counts from 0 through 255.");
        if (errors == 0 && victim_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
